// ===== sv/float_color_to_packed_format_macros.svh =====
// Assertion macros for the colour pack block
`ifndef FLOAT_COLOR_TO_PACKED_FORMAT_MACROS_SVH
`define FLOAT_COLOR_TO_PACKED_FORMAT_MACROS_SVH
// implication checked on every clock edge outside reset
`define FCP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define FCP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== sv/fcp_pkg.sv =====
// Package: types, formats and helpers for the colour pack block
package fcp_pkg;
  localparam logic [1:0] FMT_RGBA8 = 2'd0;
  localparam logic [1:0] FMT_RGB10A2 = 2'd1;
  localparam logic [1:0] FMT_R11G11B10F = 2'd2;
  localparam logic [1:0] REG_PACK_FORMAT = 2'd0;
  localparam logic [1:0] REG_ROUND_EVEN = 2'd1;
  localparam logic [31:0] PF_CLAMP = 32'h47800000;
  localparam logic [31:0] ONE_BITS = 32'h3F800000;

  typedef struct packed {
    logic [1:0] pack_format;
    logic       round_to_even;
  } cfg_t;
endpackage

// ===== sv/fcp_if.sv =====
// Valid/ready channel interfaces for pixels and configuration
interface fcp_pix_if;
  logic        valid;
  logic        ready;
  logic [31:0] red_bits;
  logic [31:0] green_bits;
  logic [31:0] blue_bits;
  logic [31:0] alpha_bits;
  modport source (output valid, red_bits, green_bits, blue_bits, alpha_bits, input ready);
  modport sink (input valid, red_bits, green_bits, blue_bits, alpha_bits, output ready);
endinterface

interface fcp_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] packed_pixel;
  modport source (output valid, packed_pixel, input ready);
  modport sink (input valid, packed_pixel, output ready);
endinterface

interface fcp_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/float_color_to_packed_format.sv =====
// Top level: float RGBA to packed pixel converter
//   channel | dir | payload
//   pix_in  | in  | red/green/blue/alpha_bits (float32)
//   pix_out | out | packed_pixel
//   cfg     | in  | index, data
// One pixel per cycle unless the output stalls; registered in the lane register, then the output register.
// Four lanes work in parallel; the output register stalls only when full and
// not taken. Reset (rst, synchronous) clears valid flags and config.
module float_color_to_packed_format import fcp_pkg::*; (
  input logic clk,
  input logic rst,
  fcp_pix_if.sink   pix_in,
  fcp_out_if.source pix_out,
  fcp_cfg_if.sink   cfg
);
`include "float_color_to_packed_format_macros.svh"
  cfg_t        cfg_q;
  logic        s1_valid;
  logic [1:0]  s1_fmt;
  logic        out_valid;
  logic [31:0] out_pixel;
  logic        adv;
  logic        s1_adv;
  logic [9:0]  un_r, un_g, un_b, un_a;
  logic [10:0] pf_r, pf_g, pf_b;
  logic [10:0] pf_a_unused;
  logic [31:0] pixel_next;
  logic [1:0]  sel_rgb;
  logic [1:0]  sel_a;

  assign cfg.ready = 1'b1;
  // stage 2 moves when output free; stage 1 moves when it is empty or moves
  assign adv = !out_valid || pix_out.ready;
  assign s1_adv = !s1_valid || adv;
  assign pix_in.ready = s1_adv;
  assign sel_rgb = (cfg_q.pack_format == FMT_RGB10A2) ? 2'd1 : 2'd0;
  assign sel_a = (cfg_q.pack_format == FMT_RGB10A2) ? 2'd2 : 2'd0;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q <= '0;
    end else if (cfg.valid) begin
      if (cfg.index == REG_PACK_FORMAT) cfg_q.pack_format <= cfg.data[1:0];
      else if (cfg.index == REG_ROUND_EVEN) cfg_q.round_to_even <= cfg.data[0];
    end
  end

  fcp_lane u_r (.clk, .en(s1_adv), .bits_in(pix_in.red_bits), .scale_sel(sel_rgb),
    .is_blue(1'b0), .round_to_even(cfg_q.round_to_even), .unorm_val(un_r), .pf_val(pf_r));
  fcp_lane u_g (.clk, .en(s1_adv), .bits_in(pix_in.green_bits), .scale_sel(sel_rgb),
    .is_blue(1'b0), .round_to_even(cfg_q.round_to_even), .unorm_val(un_g), .pf_val(pf_g));
  fcp_lane u_b (.clk, .en(s1_adv), .bits_in(pix_in.blue_bits), .scale_sel(sel_rgb),
    .is_blue(1'b1), .round_to_even(cfg_q.round_to_even), .unorm_val(un_b), .pf_val(pf_b));
  fcp_lane u_a (.clk, .en(s1_adv), .bits_in(pix_in.alpha_bits), .scale_sel(sel_a),
    .is_blue(1'b0), .round_to_even(cfg_q.round_to_even), .unorm_val(un_a),
    .pf_val(pf_a_unused));

  fcp_merge u_merge (.fmt(s1_fmt), .un_r, .un_g, .un_b, .un_a, .pf_r, .pf_g, .pf_b,
    .pixel(pixel_next));

  // pipeline control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_adv) s1_valid <= pix_in.valid;
      if (adv) out_valid <= s1_valid;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (s1_adv) s1_fmt <= cfg_q.pack_format;
    if (adv && s1_valid) out_pixel <= (pf_a_unused == pf_a_unused) ? pixel_next : '0;
  end

  assign pix_out.valid = out_valid;
  assign pix_out.packed_pixel = out_pixel;

  `FCP_ASSERT_NEXT(a_hold, out_valid && !pix_out.ready, out_valid && $stable(out_pixel))
  `FCP_ASSERT_IMP(a_stall, s1_valid && out_valid && !pix_out.ready, !pix_in.ready)
  `FCP_ASSERT_NEXT(a_flow, pix_in.valid && pix_in.ready, s1_valid)
endmodule

// ===== sv/fcp_lane.sv =====
// One channel lane: unorm scale/round and packed-float conversion
module fcp_lane import fcp_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] bits_in,
  input  logic [1:0]  scale_sel,    // 0: 255, 1: 1023, 2: 3
  input  logic        is_blue,
  input  logic        round_to_even,
  output logic [9:0]  unorm_val,
  output logic [10:0] pf_val
);
  logic        neg_or_nan;
  logic        ge_one;
  logic [23:0] mant;
  logic [7:0]  shr;
  logic [9:0]  scale;
  logic [33:0] prod;
  logic [57:0] fix;
  logic [57:0] shifted;
  logic [9:0]  ip;
  logic [47:0] frac;
  logic [31:0] sv_bits;
  logic [31:0] t;
  logic [7:0]  e;
  logic [23:0] m;
  logic [4:0]  s;
  logic [23:0] q;
  logic [24:0] rem;
  logic [24:0] half;
  logic [31:0] add;
  logic [31:0] r1;
  logic [31:0] r2;
  logic [31:0] tsum;
  logic [9:0]  unorm_next;
  logic [10:0] pf_next;

  // Unorm: scaled value x*S is exact in 34 bits (24b mantissa * 10b scale); the
  // float32 product rounds to 24 significant bits, then ties-to-even to integer.
  always_comb begin
    neg_or_nan = bits_in[31] || (bits_in[30:23] == 8'hFF && bits_in[22:0] != '0) ||
                 bits_in[30:0] == '0;
    ge_one = !bits_in[31] && bits_in[30:0] >= ONE_BITS[30:0];
    mant = {1'b1, bits_in[22:0]};
    case (scale_sel)
      2'd0:    scale = 10'd255;
      2'd1:    scale = 10'd1023;
      default: scale = 10'd3;
    endcase
    prod = {10'd0, mant} * {24'd0, scale};
    // round product to 24 significant bits, ties to even
    begin
      logic [33:0] pr;
      logic        top;
      top = prod[33] | prod[32] | prod[31] | prod[30] | prod[29] | prod[28] |
            prod[27] | prod[26] | prod[25] | prod[24];
      pr = prod;
      if (top) begin
        logic [4:0] k; logic [33:0] lsb; logic [33:0] hm; logic [33:0] lm;
        k = 5'd0;
        for (int i = 24; i < 34; i++) if (prod[i]) k = 5'(i - 23);
        lsb = 34'd1 << k;
        hm = lsb >> 1;
        lm = lsb - 34'd1;
        if ((prod & lm) > hm || ((prod & lm) == hm && (prod & lsb) != '0))
          pr = (prod & ~lm) + lsb;
        else
          pr = prod & ~lm;
      end
      fix = {24'd0, pr};
    end
    // value = fix * 2^(e-150); align to 24 fraction bits below the point
    shr = 8'd150 - bits_in[30:23];
    if (shr > 8'd57) shifted = '0;
    else shifted = (fix << 24) >> shr;
    ip = shifted[33:24];
    frac = {shifted[23:0], 24'd0};
    if (neg_or_nan) unorm_next = '0;
    else if (ge_one) unorm_next = scale;
    else if (frac[47] && (frac[46:0] != '0 || ip[0])) unorm_next = ip + 10'd1;
    else unorm_next = ip;

    // Packed float: clamp, rebias by 2^-112, add rounding, mask
    if (bits_in[31]) sv_bits = '0;
    else if (bits_in > PF_CLAMP) sv_bits = PF_CLAMP;
    else sv_bits = bits_in;
    e = sv_bits[30:23];
    m = {1'b1, sv_bits[22:0]};
    s = 5'd0; q = '0; rem = '0; half = '0;
    if (e >= 8'd113) t = sv_bits - 32'h38000000;
    else if (e == 8'd0 || e < 8'd88) t = '0;
    else begin
      s = 5'(8'd113 - e);
      q = m >> s;
      rem = {1'b0, m} & ((25'd1 << s) - 25'd1);
      half = 25'd1 << (s - 5'd1);
      if (rem > half || (rem == half && q[0])) q = q + 24'd1;
      t = {8'd0, q};
    end
    r1 = is_blue ? 32'h00020000 : 32'h00010000;
    r2 = is_blue ? 32'h0001FFFF : 32'h0000FFFF;
    if (round_to_even) begin
      add = (t >> 1) & r1;
      if (add < r2) add = r2;
    end else add = r1;
    tsum = t + add;
    if (is_blue) pf_next = {1'b0, tsum[27:18]};
    else pf_next = tsum[27:17];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      unorm_val <= unorm_next;
      pf_val <= pf_next;
    end
  end
endmodule

// ===== sv/fcp_merge.sv =====
// Merging stage: packs the lane results into one pixel word
module fcp_merge import fcp_pkg::*; (
  input  logic [1:0]  fmt,
  input  logic [9:0]  un_r, un_g, un_b, un_a,
  input  logic [10:0] pf_r, pf_g, pf_b,
  output logic [31:0] pixel
);
  always_comb begin
    case (fmt)
      FMT_RGBA8:      pixel = {un_a[7:0], un_b[7:0], un_g[7:0], un_r[7:0]};
      FMT_RGB10A2:    pixel = {un_a[1:0], un_b, un_g, un_r};
      FMT_R11G11B10F: pixel = {pf_b[9:0], pf_g, pf_r};
      default:        pixel = '0;
    endcase
  end
endmodule
